/* rtl/mexp_pkg.sv */
// Package for the modular exponentiation block: sequencer state type and
// register address constants. No dependencies.
`default_nettype none

package mexp_pkg;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_INIT,
    S_LOOP,
    S_DONE
  } state_t;

  // Register indexes on the configuration port (byte address bit 2)
  localparam logic REG_EXPONENT = 1'b0;
  localparam logic REG_MODULUS  = 1'b1;

endpackage

`default_nettype wire

/* rtl/modular_exponentiation.sv */
// Modular exponentiation, right-to-left square-and-multiply on two bit-serial
// interleaved modular multipliers. Depends on mexp_pkg.
//
//   channel   signals                               beat
//   input     in_valid / in_ready                   value, bypass
//   output    out_valid / out_ready                 result
//   config    psel penable pwrite paddr pwdata      exponent @0x0, modulus @0x4
//
// Steps: an exponentiating item first reduces the base, then works through the
// W exponent bits, one multiplier bit per cycle for each multiply;
// square and multiply run side by side.
// A bypassed item goes straight to the done state. One item is in flight at a time.
// Reset (rst, synchronous) restores the register defaults and empties the block.
// A result waiting on out_ready holds the block in its done state; the next
// item can be accepted once the result has moved to the output register.
`default_nettype none

module modular_exponentiation #(
  parameter int WORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] value,
  input  wire logic        bypass,
  // output channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      result,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mexp_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int CW = (W > 1) ? $clog2(W) : 1;
  localparam logic [CW-1:0] LAST = CW'(W - 1);
  localparam logic [31:0] EXP_RST = 32'd77239747;
  localparam logic [31:0] MOD_RST = 32'd100980637;

  // One step of interleaved modular multiply: (2r + abit*b) mod m.
  // m == 0 wraps to W bits.
  function automatic logic [W-1:0] mstep(input logic [W-1:0] r, input logic abit,
                                         input logic [W-1:0] b, input logic [W-1:0] m);
    logic [W:0]   t;
    logic [W:0]   u;
    logic [W-1:0] t1;
    logic [W-1:0] addend;
    t      = {r, 1'b0};
    addend = abit ? b : '0;
    if (m == '0) begin
      mstep = t[W-1:0] + addend;
    end else begin
      t1 = (t >= {1'b0, m}) ? W'(t - {1'b0, m}) : t[W-1:0];
      u  = {1'b0, t1} + {1'b0, addend};
      mstep = (u >= {1'b0, m}) ? W'(u - {1'b0, m}) : u[W-1:0];
    end
  endfunction

  // Configuration registers
  logic [W-1:0] exponent;
  logic [W-1:0] modulus;
  logic         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= EXP_RST[W-1:0];
      modulus  <= MOD_RST[W-1:0];
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_EXPONENT: exponent <= pwdata[W-1:0];
        REG_MODULUS:  modulus  <= pwdata[W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_EXPONENT: prdata = 32'(exponent);
      REG_MODULUS:  prdata = 32'(modulus);
      default:      prdata = '0;
    endcase
  end

  // Sequencer
  state_t state, state_next;
  logic [CW-1:0] mul_cnt;
  logic [CW-1:0] exp_cnt;
  logic          in_acc;
  logic          out_load;
  logic          mul_last;

  assign in_acc   = in_valid & in_ready;
  assign out_load = (state == S_DONE) & (~out_valid | out_ready);
  assign mul_last = (mul_cnt == LAST);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = bypass ? S_DONE : S_INIT;
      end
      S_INIT: if (mul_last) state_next = S_LOOP;
      S_LOOP: if (mul_last && exp_cnt == LAST) state_next = S_DONE;
      S_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath: acc * sq on r1, sq * sq on r2, multiplier bits shift out MSB first
  logic [W-1:0] acc, sq, aa, sa, r1, r2, e_sh, res;
  logic [W-1:0] one_red, nr1, nr2, acc_new;

  assign one_red = (modulus == W'(1)) ? '0 : W'(1);
  assign nr1     = mstep(r1, aa[W-1], sq, modulus);
  assign nr2     = mstep(r2, sa[W-1], sq, modulus);
  assign acc_new = e_sh[0] ? nr1 : acc;

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (in_acc) begin
        res     <= value[W-1:0];
        sa      <= value[W-1:0];
        sq      <= one_red;
        acc     <= one_red;
        r1      <= '0;
        r2      <= '0;
        e_sh    <= exponent;
        mul_cnt <= '0;
        exp_cnt <= '0;
      end
      S_INIT: begin
        // base mod m, as base * 1 mod m
        if (mul_last) begin
          sq      <= nr2;
          sa      <= nr2;
          aa      <= acc;
          r1      <= '0;
          r2      <= '0;
          mul_cnt <= '0;
        end else begin
          r2      <= nr2;
          sa      <= sa << 1;
          mul_cnt <= mul_cnt + CW'(1);
        end
      end
      S_LOOP: begin
        if (mul_last) begin
          acc     <= acc_new;
          aa      <= acc_new;
          sq      <= nr2;
          sa      <= nr2;
          r1      <= '0;
          r2      <= '0;
          e_sh    <= e_sh >> 1;
          mul_cnt <= '0;
          exp_cnt <= exp_cnt + CW'(1);
          res     <= acc_new;
        end else begin
          r1      <= nr1;
          r2      <= nr2;
          aa      <= aa << 1;
          sa      <= sa << 1;
          mul_cnt <= mul_cnt + CW'(1);
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) result <= 32'(res);
  end

endmodule

`default_nettype wire

/* rtl/mexp_checker.sv */
// Port-level checks for modular_exponentiation, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module mexp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] result,
  input wire logic        pready
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result))
    else $error("result beat changed while stalled");

  // one item in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item was in flight");

  // a new result comes from a busy block, never from idle
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> !$past(in_ready))
    else $error("result appeared without work in flight");

  // config port never stalls
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .result    (result),
  .pready    (pready)
);

`default_nettype wire
